### hw/rtl/hsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_pkg: shared constants for the steep slope detector
// Register indexes, field widths and register reset values.
// ----------------------------------------------------------------------------
package hsd_pkg;

  // Configuration port geometry
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  // Register widths
  localparam int ROW_LEN_W = 11;
  localparam int ROW_CNT_W = 16;
  localparam int LIMIT_W   = 24;

  // Result coordinate widths
  localparam int CELL_X_W = 10;
  localparam int CELL_Z_W = 16;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW_LENGTH  = 2'd0,
    CFG_ROW_COUNT   = 2'd1,
    CFG_DELTA_LIMIT = 2'd2,
    CFG_RULE_ENABLE = 2'd3
  } cfg_index_t;

  // Register reset values
  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST  = 11'd1024;
  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST   = 16'd1024;
  localparam logic [LIMIT_W-1:0]   DELTA_LIMIT_RST = 24'd2926;
  localparam logic                 RULE_ENABLE_RST = 1'b1;

endpackage

### hw/rtl/hsd_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsd_line_buf: previous-row line buffer
// Simple dual-port memory, one write and one registered read per cycle.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module hsd_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 49,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/heightmap_steep_slope_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_steep_slope_detector: steep slope detector for raster heightmaps
// Takes cells in raster order, compares each cell with its +X and +Z
// neighbours and reports cells whose largest difference exceeds the limit.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid/in_ready   | in_height, in_is_hole
//  out     | out       | out_valid/out_ready | out_cell_x, out_cell_z, out_max_delta,
//          |           |                     | out_cell_height, out_last_in_run
//
//  One cell per clock unless a stalled output holds the input: each cell costs
//  one line-buffer read and at most one write. A cell is held in stage 1 and
//  its results are registered into the output buffer. A cell that makes two
//  results fills both output slots, so a following cell that reports waits
//  until the buffer can take it. The two-entry output buffer sets this.
//  Synchronous active-low reset clears counters, the previous cell and
//  the pipeline; the line buffer has no reset. cfg_ready is always high.
//  A stalled output holds the result stage, which then holds the input.
// ----------------------------------------------------------------------------
module heightmap_steep_slope_detector
  import hsd_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int HEIGHT_BITS    = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  // cell input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [HEIGHT_BITS-1:0] in_height,
  input  logic                          in_is_hole,
  // report output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CELL_X_W-1:0]           out_cell_x,
  output logic [CELL_Z_W-1:0]           out_cell_z,
  output logic [HEIGHT_BITS-1:0]        out_max_delta,
  output logic signed [HEIGHT_BITS-1:0] out_cell_height,
  output logic                          out_last_in_run
);

  localparam int HB = HEIGHT_BITS;
  localparam int CW = $clog2(MAX_ROW_LENGTH);
  localparam int LW = (CW + 1 > ROW_LEN_W) ? CW + 1 : ROW_LEN_W;
  localparam int DW = (HB > LIMIT_W) ? HB : LIMIT_W;
  localparam int EW = 2 * HB + 1;

  typedef struct packed {
    logic [CELL_X_W-1:0] x;
    logic [CELL_Z_W-1:0] z;
    logic [HB-1:0]       d;
    logic [HB-1:0]       h;
    logic                last;
  } res_t;

  function automatic logic [HB-1:0] abs_diff(input logic [HB-1:0] a,
                                             input logic [HB-1:0] b);
    logic [HB:0] diff;
    logic [HB:0] mag;
    diff = {a[HB-1], a} - {b[HB-1], b};
    mag  = diff[HB] ? (~diff + (HB+1)'(1)) : diff;
    return mag[HB-1:0];
  endfunction

  function automatic logic over_limit(input logic [HB-1:0]      d,
                                      input logic [LIMIT_W-1:0] lim);
    return DW'(d) > DW'(lim);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [ROW_LEN_W-1:0] row_length_r;
  logic [ROW_CNT_W-1:0] row_count_r;
  logic [LIMIT_W-1:0]   delta_limit_r;
  logic                 rule_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r  <= ROW_LENGTH_RST;
      row_count_r   <= ROW_COUNT_RST;
      delta_limit_r <= DELTA_LIMIT_RST;
      rule_enable_r <= RULE_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_ROW_LENGTH:  row_length_r  <= cfg_data[ROW_LEN_W-1:0];
        CFG_ROW_COUNT:   row_count_r   <= cfg_data[ROW_CNT_W-1:0];
        CFG_DELTA_LIMIT: delta_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_RULE_ENABLE: rule_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input position: clamp the map size and find the last column and row
  // --------------------------------------------------------------------------
  logic [CW-1:0]        col_r, col_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;
  logic [LW-1:0]        row_len_ext;
  logic [LW-1:0]        len_c;
  logic [ROW_CNT_W-1:0] cnt_c;
  logic                 in_last_col;
  logic                 in_last_row;
  logic                 in_xfer;

  assign in_xfer     = in_valid && in_ready;
  assign row_len_ext = LW'(row_length_r);
  assign cnt_c       = (row_count_r == '0) ? ROW_CNT_W'(1) : row_count_r;

  always_comb begin
    if (row_len_ext == '0) begin
      len_c = LW'(1);
    end else if (row_len_ext > LW'(MAX_ROW_LENGTH)) begin
      len_c = LW'(MAX_ROW_LENGTH);
    end else begin
      len_c = row_len_ext;
    end
  end

  assign in_last_col = (LW'(col_r) + LW'(1)) >= len_c;
  assign in_last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, cnt_c};

  // Advance the position on each input transfer
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_xfer) begin
      if (in_last_col) begin
        col_nxt = '0;
        row_nxt = in_last_row ? '0 : row_r + ROW_CNT_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line buffer
  // --------------------------------------------------------------------------
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] mem_q;

  hsd_line_buf #(
    .DEPTH (MAX_ROW_LENGTH),
    .WIDTH (EW),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_xfer),
    .rd_addr (col_r),
    .rd_data (mem_q)
  );

  // --------------------------------------------------------------------------
  // Stage 1: cell register
  // --------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [HB-1:0]        s1_h_r;
  logic                 s1_hole_r;
  logic [CW-1:0]        s1_x_r;
  logic [ROW_CNT_W-1:0] s1_z_r;
  logic                 s1_last_col_r;
  logic                 s1_last_row_r;
  logic                 fwd_hit_r;
  logic [EW-1:0]        fwd_data_r;
  logic                 s1_adv;

  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Hold the cell and capture any write that lands on the read address
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_h_r        <= in_height;
      s1_hole_r     <= in_is_hole;
      s1_x_r        <= col_r;
      s1_z_r        <= row_r;
      s1_last_col_r <= in_last_col;
      s1_last_row_r <= in_last_row;
      fwd_hit_r     <= wr_en && (wr_addr == col_r);
      fwd_data_r    <= wr_data;
    end
  end

  // Previous cell of the current row, and the held last-column entry
  logic          prev_hole_r, prev_hole_nxt;
  logic [HB-1:0] prev_h_r, prev_h_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  logic [CW-1:0] pend_addr_r, pend_addr_nxt;
  logic [EW-1:0] pend_data_r, pend_data_nxt;

  // --------------------------------------------------------------------------
  // Slope evaluation
  // --------------------------------------------------------------------------
  logic [EW-1:0] ent;
  logic [HB-1:0] e_h;
  logic          e_hole;
  logic [HB-1:0] e_xd;
  logic [HB-1:0] dz;
  logic [HB-1:0] d_a;
  logic [HB-1:0] dx;
  logic          a_v;
  logic          b_v;
  logic [1:0]    nres;
  res_t          res_a;
  res_t          res_b;
  logic [CW-1:0] px;

  // Pick the newest copy of the previous-row entry
  always_comb begin
    if (pend_valid_r && (pend_addr_r == s1_x_r)) begin
      ent = pend_data_r;
    end else if (fwd_hit_r) begin
      ent = fwd_data_r;
    end else begin
      ent = mem_q;
    end
  end

  assign e_h    = ent[EW-1 -: HB];
  assign e_hole = ent[HB];
  assign e_xd   = ent[HB-1:0];
  assign px     = s1_x_r - CW'(1);

  // Cell above: its stored +X difference against the new +Z difference
  assign dz  = (!s1_hole_r && !e_hole) ? abs_diff(s1_h_r, e_h) : '0;
  assign d_a = (dz > e_xd) ? dz : e_xd;
  assign a_v = (s1_z_r != '0) && rule_enable_r && !e_hole &&
               over_limit(d_a, delta_limit_r);

  // Cell to the left: +X difference, reported directly on the last row
  assign dx  = (!s1_hole_r && !prev_hole_r) ? abs_diff(s1_h_r, prev_h_r) : '0;
  assign b_v = (s1_x_r != '0) && s1_last_row_r && rule_enable_r && !prev_hole_r &&
               over_limit(dx, delta_limit_r);

  always_comb begin
    res_a.x    = CELL_X_W'(s1_x_r);
    res_a.z    = s1_z_r - ROW_CNT_W'(1);
    res_a.d    = d_a;
    res_a.h    = e_h;
    res_a.last = !b_v;
    res_b.x    = CELL_X_W'(px);
    res_b.z    = s1_z_r;
    res_b.d    = dx;
    res_b.h    = prev_h_r;
    res_b.last = 1'b1;
  end

  assign nres = {1'b0, a_v} + {1'b0, b_v};

  // --------------------------------------------------------------------------
  // Line buffer update on stage advance
  // --------------------------------------------------------------------------
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = px;
    wr_data        = {prev_h_r, prev_hole_r, dx};
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_data_nxt  = pend_data_r;
    prev_h_nxt     = prev_h_r;
    prev_hole_nxt  = prev_hole_r;
    if (s1_adv) begin
      prev_h_nxt    = s1_h_r;
      prev_hole_nxt = s1_hole_r;
      if (s1_x_r != '0) begin
        wr_en = 1'b1;
      end else if (pend_valid_r) begin
        // flush the held last-column entry into the free write slot
        wr_en          = 1'b1;
        wr_addr        = pend_addr_r;
        wr_data        = pend_data_r;
        pend_valid_nxt = 1'b0;
      end
      if (s1_last_col_r) begin
        pend_valid_nxt = 1'b1;
        pend_addr_nxt  = s1_x_r;
        pend_data_nxt  = {s1_h_r, s1_hole_r, {HB{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_h_r     <= '0;
      prev_hole_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      prev_h_r     <= prev_h_nxt;
      prev_hole_r  <= prev_hole_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
  end

  // --------------------------------------------------------------------------
  // Output buffer: two result slots, slot 0 is presented
  // --------------------------------------------------------------------------
  logic [1:0] ocnt_r, ocnt_nxt;
  res_t       slot0_r, slot0_nxt;
  res_t       slot1_r, slot1_nxt;
  logic       pop;
  logic       buf_free;
  logic       load;

  assign out_valid = ocnt_r != 2'd0;
  assign pop       = out_valid && out_ready;
  assign buf_free  = (ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && out_ready);
  assign s1_adv    = s1_valid_r && ((nres == 2'd0) || buf_free);
  assign load      = s1_adv && (nres != 2'd0);

  // Load results in order, or shift after a transfer
  always_comb begin
    ocnt_nxt  = ocnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      ocnt_nxt  = nres;
      slot0_nxt = a_v ? res_a : res_b;
      slot1_nxt = res_b;
    end else if (pop) begin
      ocnt_nxt  = ocnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_cell_x      = slot0_r.x;
  assign out_cell_z      = slot0_r.z;
  assign out_max_delta   = slot0_r.d;
  assign out_cell_height = slot0_r.h;
  assign out_last_in_run = slot0_r.last;

endmodule
